// ===== src/like_pattern_matcher_core_assert.svh =====
// assertion macros for the like pattern matcher checker
// expects clk_i and rst_ni in the scope of use
`ifndef LIKE_PATTERN_MATCHER_CORE_ASSERT_SVH
`define LIKE_PATTERN_MATCHER_CORE_ASSERT_SVH

// same-cycle implication
`define LPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpm assertion failed");

// next-cycle implication
`define LPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpm assertion failed");

`endif

// ===== src/lpm_pkg.sv =====
// shared types, character codes and helpers of the like pattern matcher
// no dependencies
`timescale 1ns / 1ps

package lpm_pkg;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_MANY = 2'd2
  } kind_e;

  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_OFFSET     = 8'd32;

  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned PatLenWidth  = 5;

  localparam logic [1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [1:0] CFG_PAT_LEN  = 2'd2;

  // ascii a..z to upper case, everything else unchanged
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== src/like_pattern_matcher_core.sv =====
// case-insensitive sql like matcher, top level
// depends on lpm_pkg
`timescale 1ns / 1ps

// Matches a stream of text bytes against a configured LIKE pattern ('%' any
// run, '_' one byte, backslash escapes the next byte, ascii letters compared
// without case). One text byte is taken per cycle while in_ready_o is high;
// the result of a text is available in the cycle after its last item and
// waits in a two-entry output queue, so input keeps flowing while one result
// is not yet taken. After any write to a pattern register the pattern is
// split into tokens by a sequencer that handles one token per cycle, and
// in_ready_o stays low meanwhile; a write also restarts the text in progress.
module like_pattern_matcher_core
  import lpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              text_byte_i,
  input  logic                    has_byte_i,
  input  logic                    last_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    matched_o
);

  localparam int unsigned NPos = MAX_PATTERN_BYTES + 1;
  localparam int unsigned CW   = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned IW   = $clog2(MAX_PATTERN_BYTES);
  localparam int unsigned FifoDepth = 2;

  // configuration registers
  logic [CfgDataWidth-1:0] pat_low_q, pat_high_q;
  logic [PatLenWidth-1:0]  pat_len_q;
  logic                    cfg_wr;

  // tokenizer
  logic            busy_q;
  logic [CW-1:0]   idx_q, ntok_q, count_q;
  logic [CW-1:0]   len_eff, idx_nx1;
  logic [2*CfgDataWidth-1:0] pat_all;
  logic [7:0]      cur_c, nxt_c;
  logic            tok_more, is_esc;
  kind_e           tok_kind;
  logic [7:0]      tok_lit;
  kind_e           kind_q [MAX_PATTERN_BYTES];
  logic [7:0]      lit_q  [MAX_PATTERN_BYTES];

  // matcher
  logic            start_q;
  logic [NPos-1:0] live_q, live_cur, nxt, closed, live_after, reach0;
  logic [MAX_PATTERN_BYTES-1:0] many;
  logic [NPos-1:0] span [NPos];
  logic [7:0]      in_c;
  logic            in_fire, match_val;

  // output queue
  logic [1:0]      cnt_q;
  logic            wr_q, rd_q;
  logic            res_q [FifoDepth];
  logic            push, pop;

  assign cfg_wr = cfg_we_i && (cfg_index_i <= CFG_PAT_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[PatLenWidth-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- tokenizer ----------------
  assign pat_all = {pat_high_q, pat_low_q};
  assign len_eff = (pat_len_q > PatLenWidth'(MAX_PATTERN_BYTES)) ?
                   CW'(MAX_PATTERN_BYTES) : pat_len_q[CW-1:0];
  assign idx_nx1 = idx_q + CW'(1);
  assign cur_c   = fold_upper(pat_all[{idx_q[IW-1:0], 3'b000} +: 8]);
  assign nxt_c   = fold_upper(pat_all[{idx_nx1[IW-1:0], 3'b000} +: 8]);
  assign tok_more = idx_q < len_eff;
  // a backslash in the last used byte stays a literal
  assign is_esc  = (cur_c == CHAR_BACKSLASH) && (idx_nx1 < len_eff);

  always_comb begin
    tok_kind = KIND_LIT;
    tok_lit  = cur_c;
    if (is_esc) begin
      tok_lit = nxt_c;
    end else if (cur_c == CHAR_PERCENT) begin
      tok_kind = KIND_MANY;
    end else if (cur_c == CHAR_UNDERSCORE) begin
      tok_kind = KIND_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      ntok_q  <= '0;
      count_q <= '0;
    end else if (cfg_wr) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      ntok_q <= '0;
    end else if (busy_q) begin
      if (tok_more) begin
        idx_q  <= is_esc ? idx_q + CW'(2) : idx_nx1;
        ntok_q <= ntok_q + CW'(1);
      end else begin
        busy_q  <= 1'b0;
        count_q <= ntok_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && tok_more && !cfg_wr) begin
      kind_q[ntok_q[IW-1:0]] <= tok_kind;
      lit_q[ntok_q[IW-1:0]]  <= tok_lit;
    end
  end

  // ---------------- matcher ----------------
  always_comb begin
    for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
      many[p] = (kind_q[p] == KIND_MANY) && (CW'(p) < count_q);
    end
  end

  // span[j][q]: position q is reachable from j through '%' tokens alone
  always_comb begin
    logic [MAX_PATTERN_BYTES-1:0] rmask;
    for (int j = 0; j < NPos; j++) begin
      for (int q = 0; q < NPos; q++) begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
          rmask[k] = (k >= j) && (k < q);
        end
        span[j][q] = (q >= j) && ((many & rmask) == rmask);
      end
    end
  end

  always_comb begin
    for (int q = 0; q < NPos; q++) begin
      reach0[q] = span[0][q];
    end
  end

  assign live_cur = start_q ? reach0 : live_q;
  assign in_c     = fold_upper(text_byte_i);

  always_comb begin
    nxt = '0;
    for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
      if (live_cur[p] && (CW'(p) < count_q)) begin
        if (kind_q[p] == KIND_MANY) begin
          nxt[p] = 1'b1;
        end else if (kind_q[p] == KIND_ONE ||
                     (kind_q[p] == KIND_LIT && lit_q[p] == in_c)) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    closed = '0;
    for (int q = 0; q < NPos; q++) begin
      for (int j = 0; j < NPos; j++) begin
        closed[q] = closed[q] | (nxt[j] & span[j][q]);
      end
    end
  end

  assign live_after = has_byte_i ? closed : live_cur;
  assign match_val  = (pat_len_q == '0) ? 1'b1 : live_after[count_q];

  assign in_ready_o = !busy_q && (cnt_q != 2'(FifoDepth));
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else if (cfg_wr) begin
      start_q <= 1'b1;
    end else if (in_fire) begin
      if (last_byte_i) begin
        start_q <= 1'b1;
      end else if (has_byte_i) begin
        start_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && has_byte_i && !last_byte_i) begin
      live_q <= closed;
    end
  end

  // ---------------- output queue ----------------
  assign push        = in_fire && last_byte_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign matched_o   = res_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_q] <= match_val;
    end
  end

endmodule

// ===== src/lpm_checker.sv =====
// port-level checks of the like pattern matcher, bound to the top level
// depends on lpm_pkg and like_pattern_matcher_core_assert.svh
`timescale 1ns / 1ps
`include "like_pattern_matcher_core_assert.svh"

module lpm_checker
  import lpm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [1:0] cfg_index_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       matched_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // a pattern write stalls input while the tokens are rebuilt
  `LPM_ASSERT_NEXT(a_cfg_stalls, cfg_we_i && (cfg_index_i <= CFG_PAT_LEN), !in_ready_o)
  // last item of a text always yields a result
  `LPM_ASSERT_NEXT(a_last_gives_result, in_xfer && last_byte_i && !out_valid_o, out_valid_o)
  // other items never invent a result
  `LPM_ASSERT_NEXT(a_no_spurious, in_xfer && !last_byte_i && !out_valid_o, !out_valid_o)
  // a stalled result holds
  `LPM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(matched_o))

endmodule

bind like_pattern_matcher_core lpm_checker u_lpm_checker (.*);

// ===== verif/tb_like_pattern_matcher_core.sv =====
// self-checking testbench for like_pattern_matcher_core: directed table, then random patterns
// and texts; expected match bits come from an in-bench matcher; depends on lpm_pkg and the rtl
`timescale 1ns / 1ps

module tb_like_pattern_matcher_core;
  import lpm_pkg::*;

  localparam int unsigned PAT_BYTES     = 16;
  localparam int          SETTLE_CYCLES = PAT_BYTES + 4;
  localparam int          ITEM_TARGET   = 1550;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_e;

  typedef struct packed {
    row_e        kind;
    logic [1:0]  idx;
    logic [63:0] data;
    logic [7:0]  text;
    logic        has;
    logic        last;
    logic        typed;  // expectation written in the row
    logic        want;
  } step_t;

  localparam int DIR_ROWS = 28;
  localparam step_t DIRECTED [DIR_ROWS] = '{
    // empty pattern after reset: empty text and any byte both match
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1},
    // "a_%"
    '{ROW_REG,  CFG_PAT_LOW,  64'h0000_0000_0025_5F61, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG,  CFG_PAT_LEN,  64'h3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
    // no byte, not last: nothing happens
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h42, 1'b1, 1'b1, 1'b0, 1'b0},
    // escaped percent, letter, trailing backslash taken literally
    '{ROW_REG,  CFG_PAT_LOW,  64'h0000_0000_5C61_255C, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG,  CFG_PAT_LEN,  64'h4, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h25, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h5C, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
    // register write in the middle of a text restarts it
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h78, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_REG,  CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h25, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h5C, 1'b1, 1'b1, 1'b0, 1'b0},
    // write to the unused index is dropped
    '{ROW_REG,  CFG_SPARE,    64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    // length above the maximum clamps; sixteen percents match anything
    '{ROW_REG,  CFG_PAT_LOW,  64'h2525_2525_2525_2525, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG,  CFG_PAT_HIGH, 64'h2525_2525_2525_2525, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG,  CFG_PAT_LEN,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
    // zero length matches everything whatever the pattern bytes
    '{ROW_REG,  CFG_PAT_LEN,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, CFG_PAT_LOW,  64'h0, 8'h7A, 1'b1, 1'b1, 1'b1, 1'b1}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [1:0]              cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [7:0]              text_byte_i;
  logic                    has_byte_i;
  logic                    last_byte_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    matched_o;

  like_pattern_matcher_core #(
    .MAX_PATTERN_BYTES(PAT_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .text_byte_i(text_byte_i),
    .has_byte_i (has_byte_i),
    .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .matched_o  (matched_o)
  );

  // matcher state mirrored in the bench
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;
  kind_e       tok_kind [16];
  logic [7:0]  tok_lit  [16];
  int unsigned tok_cnt;
  logic [16:0] live;

  logic match_q [$];
  bit   sender_idles;
  bit   sink_idles;
  int   items_sent;
  int   results_seen;
  int   hits;
  int   bad_count;
  int   phases;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return c - CASE_OFFSET;
    return c;
  endfunction

  // follow percent tokens, which match without taking a byte
  function automatic logic [16:0] close_runs(input logic [16:0] s);
    for (int p = 0; p < tok_cnt; p++)
      if (s[p] && tok_kind[p] == KIND_MANY) s[p+1] = 1'b1;
    return s;
  endfunction

  function automatic void split_pattern();
    logic [127:0] all;
    logic [7:0]   c;
    int unsigned  n_used;
    int unsigned  i;
    int unsigned  n;
    all    = {pat_hi, pat_lo};
    n_used = (pat_len > PAT_BYTES) ? PAT_BYTES : pat_len;
    i      = 0;
    n      = 0;
    for (int k = 0; k < 16; k++) begin
      tok_kind[k] = KIND_LIT;
      tok_lit[k]  = 8'h00;
    end
    while (i < n_used) begin
      c = upcase(all[8*i +: 8]);
      if (c == CHAR_BACKSLASH && i + 1 < n_used) begin
        tok_kind[n] = KIND_LIT;
        tok_lit[n]  = upcase(all[8*(i+1) +: 8]);
        i += 2;
      end else if (c == CHAR_PERCENT) begin
        tok_kind[n] = KIND_MANY;
        i++;
      end else if (c == CHAR_UNDERSCORE) begin
        tok_kind[n] = KIND_ONE;
        i++;
      end else begin
        tok_kind[n] = KIND_LIT;
        tok_lit[n]  = c;
        i++;
      end
      n++;
    end
    tok_cnt = n;
    live    = close_runs(17'd1);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [63:0] v);
    case (idx)
      CFG_PAT_LOW:  pat_lo = v;
      CFG_PAT_HIGH: pat_hi = v;
      CFG_PAT_LEN:  pat_len = v[4:0];
      default: return;
    endcase
    split_pattern();
  endfunction

  // advance the live set by one item; returns 1 when the item ends a text
  function automatic bit match_step(input logic [7:0] b, input logic has, input logic last,
                                    output logic m);
    logic [7:0]  c;
    logic [16:0] nxt;
    c = upcase(b);
    m = 1'b0;
    if (has) begin
      nxt = '0;
      for (int p = 0; p < tok_cnt; p++) begin
        if (live[p]) begin
          if (tok_kind[p] == KIND_MANY) nxt[p] = 1'b1;
          else if (tok_kind[p] == KIND_ONE) nxt[p+1] = 1'b1;
          else if (tok_kind[p] == KIND_LIT && tok_lit[p] == c) nxt[p+1] = 1'b1;
        end
      end
      live = close_runs(nxt);
    end
    if (!last) return 1'b0;
    m    = (pat_len == 5'd0) ? 1'b1 : live[tok_cnt];
    live = close_runs(17'd1);
    return 1'b1;
  endfunction

  function automatic int pause_len(input bit on);
    return on ? int'($urandom_range(0, 10)) : 0;
  endfunction

  // small alphabet so that patterns and texts meet often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h61;  // a
      1: return 8'h41;  // A
      2: return 8'h62;  // b
      3: return 8'h42;  // B
      4: return CHAR_PERCENT;
      5: return CHAR_UNDERSCORE;
      6: return CHAR_BACKSLASH;
      7: return 8'h63;  // c
      8: return 8'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? 8'h60 : 8'h7B;  // just outside a..z
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic has, input logic last,
                           input logic typed, input logic want);
    int   gap;
    logic m;
    gap = pause_len(sender_idles);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    has_byte_i  <= has;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (has || last) items_sent++;
    if (match_step(b, has, last, m)) match_q.insert(match_q.size(), typed ? want : m);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
  endtask

  // hold the sender until every result is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_text();
    logic [7:0] txt [$];
    int         mode;
    int         k;
    int         run;
    bit         tail_empty;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      // build a text the pattern accepts, then sometimes damage it
      for (int p = 0; p < tok_cnt; p++) begin
        if (tok_kind[p] == KIND_LIT) begin
          if (tok_lit[p] >= 8'h41 && tok_lit[p] <= 8'h5A && $urandom_range(0, 1))
            txt.insert(txt.size(), tok_lit[p] + CASE_OFFSET);
          else
            txt.insert(txt.size(), tok_lit[p]);
        end else if (tok_kind[p] == KIND_ONE) begin
          txt.insert(txt.size(), pick_byte());
        end else begin
          run = $urandom_range(0, 3);
          repeat (run) txt.insert(txt.size(), pick_byte());
        end
      end
      if ($urandom_range(0, 3) == 0 && txt.size() != 0) begin
        if ($urandom_range(0, 1)) txt[$urandom_range(0, txt.size() - 1)] = pick_byte();
        else void'(txt.pop_back());
      end
    end else if (mode <= 8) begin
      run = $urandom_range(0, 12);
      repeat (run) txt.insert(txt.size(), pick_byte());
    end
    tail_empty = (txt.size() != 0) && ($urandom_range(0, 7) == 0);
    if (txt.size() == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0);
    for (k = 0; k < txt.size(); k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0);
      send_item(txt[k], 1'b1, (k == txt.size() - 1) && !tail_empty, 1'b0, 1'b0);
    end
    if (tail_empty) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic new_pattern();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    int          pick;
    lo       = {$urandom, $urandom};
    hi       = {$urandom, $urandom};
    len_word = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_byte();
      hi[8*i +: 8] = pick_byte();
    end
    case ($urandom_range(0, 15))
      0: lo = '0;
      1: lo = '1;
      2: hi = '0;
      3: hi = '1;
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) len_word[4:0] = 5'd0;
    else if (pick == 1) len_word[4:0] = 5'd16;
    else if (pick == 2) len_word[4:0] = 5'($urandom_range(17, 31));
    else len_word[4:0] = 5'($urandom_range(1, 16));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_PAT_LOW, lo);
    if ($urandom_range(0, 3) != 0) write_reg(CFG_PAT_HIGH, hi);
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
    if ($urandom_range(0, 4) != 0) write_reg(CFG_PAT_LEN, len_word);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pause_len(sink_idles);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (matched_o === 1'b1) hits++;
      if (match_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("result with none expected: matched=%b", matched_o);
      end else begin
        want = match_q.pop_front();
        if (matched_o !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display("match result %0d: expected %b, got %b", results_seen, want, matched_o);
        end
      end
    end
  end

  initial begin : stimulus
    bit prev_reg;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_PAT_LOW;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    text_byte_i  <= 8'h00;
    has_byte_i   <= 1'b0;
    last_byte_i  <= 1'b0;
    items_sent   = 0;
    results_seen = 0;
    hits         = 0;
    bad_count    = 0;
    phases       = 0;
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    pat_lo       = '0;
    pat_hi       = '0;
    pat_len      = '0;
    split_pattern();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    prev_reg = 1'b0;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        if (!prev_reg) settle();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        if (prev_reg) cfg_we_i <= 1'b0;
        send_item(DIRECTED[r].text, DIRECTED[r].has, DIRECTED[r].last,
                  DIRECTED[r].typed, DIRECTED[r].want);
      end
      prev_reg = (DIRECTED[r].kind == ROW_REG);
    end

    while (items_sent < ITEM_TARGET) begin
      settle();
      phases++;
      sender_idles = ($urandom_range(0, 3) != 0);
      sink_idles   = ($urandom_range(0, 3) != 0);
      new_pattern();
      repeat ($urandom_range(3, 10)) send_text();
    end

    settle();
    $display("run covered %0d text items over %0d random pattern settings", items_sent, phases);
    $display("%0d match results checked, %0d of them matching", results_seen, hits);
    if (bad_count == 0 && match_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
